// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/bspq_pkg.sv
// ---------------------------------------------------------------------------
// bspq_pkg
// Types and codes of the bounded sorted priority queue.
// ---------------------------------------------------------------------------
package bspq_pkg;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_DISABLED = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   localparam int CONF_W  = 16;
   localparam int TAG_W   = 32;
   localparam int COUNT_OUT_W = 5;

   typedef struct packed {
      logic [CONF_W-1:0] confidence;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// File: rtl/bspq_cell.sv
// ---------------------------------------------------------------------------
// bspq_cell
// One slot of the sorted row: compare against the new entry, then keep,
// take the new entry or shift from a neighbor.
// ---------------------------------------------------------------------------
module bspq_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                   clock,
   input  bspq_pkg::cell_ctrl_type ctrl,
   input  bspq_pkg::entry_type    new_entry,
   input  bspq_pkg::entry_type    left_entry,
   input  logic                   left_keep,
   input  bspq_pkg::entry_type    right_entry,
   input  logic [COUNT_W-1:0]     count,
   output logic                   keep,
   output bspq_pkg::entry_type    entry,
   output bspq_pkg::entry_type    entry_next
);
   import bspq_pkg::*;

   localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   assign occupied = IDX < count;
   // stored entry ranks strictly above the new one: it stays put
   assign keep     = occupied && (entry_ff.confidence > new_entry.confidence);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            entry_in = left_keep ? new_entry : left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// File: rtl/bounded_sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// bounded_sorted_priority_queue
// Sorted store of up to MAX_ENTRIES (confidence, tag) entries, highest first,
// built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/ready, cmd, confidence, tag   | in
//  rsp     | rsp_valid/ready, status, top_*, count   | out
//  csr     | csr_valid/ready, csr_queue_enable       | in
//
//  Every cell compares and shifts in the cycle the request is accepted;
//  the response lands in an output register.
//  A new request is taken while the response is taken, so one per cycle.
//  Reset clears the fill count, the enable and the response valid; slot
//  contents are left as they are and only slots below the count are read.
//  A stalled response holds the request channel off.
//
module bounded_sorted_priority_queue #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [bspq_pkg::CONF_W-1:0]     req_entry_confidence,
   input  logic [bspq_pkg::TAG_W-1:0]      req_entry_tag,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_top_valid,
   output logic [bspq_pkg::CONF_W-1:0]     rsp_top_confidence,
   output logic [bspq_pkg::TAG_W-1:0]      rsp_top_tag,
   output logic [bspq_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_queue_enable
);
   import bspq_pkg::*;

   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ENTRIES);
   localparam logic [COUNT_W-1:0] ONE       = COUNT_W'(1);

   logic               enable_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff;
   logic [1:0]         status_ff;
   logic               top_valid_ff;
   entry_type          top_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff;

   logic               accept;
   cell_ctrl_type      ctrl;
   entry_type          new_entry;
   status_type         status;
   logic               top_valid;
   logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

   entry_type cell_entry [MAX_ENTRIES];
   entry_type cell_next  [MAX_ENTRIES];
   logic      cell_keep  [MAX_ENTRIES];

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign new_entry.confidence = req_entry_confidence;
   assign new_entry.tag        = req_entry_tag;

   // decode the request against enable and fill level
   always_comb begin
      ctrl     = '0;
      status   = STATUS_DONE;
      count_in = count_ff;
      if (!enable_ff) begin
         status = STATUS_DISABLED;
      end else if (req_cmd == CMD_INSERT) begin
         ctrl.insert = accept;
         // a full store drops either the tail or the new entry itself
         if (count_ff < MAX_COUNT) begin
            count_in = count_ff + ONE;
         end
      end else if (count_ff == '0) begin
         status = STATUS_EMPTY;
      end else begin
         ctrl.remove = accept;
         count_in    = count_ff - ONE;
      end
   end

   // the cell row; slot 0 is the top of the queue
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_keep;
      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         // slot past the end after a remove is beyond the count
         assign right_entry = new_entry;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end
      bspq_cell #(
         .INDEX   (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .count       (count_ff),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i]),
         .entry_next  (cell_next[i])
      );
   end

   assign top_valid = enable_ff && (count_in != '0);
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_queue_enable;
         end
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status;
         top_valid_ff <= top_valid;
         top_ff       <= top_valid ? cell_next[0] : '0;
         count_out_ff <= count_ext[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_top_valid      = top_valid_ff;
   assign rsp_top_confidence = top_ff.confidence;
   assign rsp_top_tag        = top_ff.tag;
   assign rsp_entry_count    = count_out_ff;

endmodule

// File: rtl/bspq_checker.sv
// ---------------------------------------------------------------------------
// bspq_checker
// Port-level checks of the priority queue responses.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bspq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic                              rsp_top_valid,
   input logic [bspq_pkg::CONF_W-1:0]       rsp_top_confidence,
   input logic [bspq_pkg::TAG_W-1:0]        rsp_top_tag,
   input logic [bspq_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);
   import bspq_pkg::*;

   // refused transactions report no top entry
   `ASSERT_IMPL(a_disabled_no_top, clock, reset,
      rsp_valid && (rsp_status == STATUS_DISABLED),
      !rsp_top_valid && (rsp_top_confidence == '0) && (rsp_top_tag == '0))

   // remove on empty leaves an empty queue
   `ASSERT_IMPL(a_empty_remove, clock, reset,
      rsp_valid && (rsp_status == STATUS_EMPTY),
      !rsp_top_valid && (rsp_entry_count == '0))

   // only the three defined status codes appear
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid,
      (rsp_status == STATUS_DONE) || (rsp_status == STATUS_DISABLED) ||
      (rsp_status == STATUS_EMPTY))

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_top_tag) &&
      $stable(rsp_top_confidence) && $stable(rsp_entry_count))

endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (.*);
